/* hdl/radix_digit_sum_and_root_assert.svh */
// ----------------------------------------------------------------------------
// radix_digit_sum_and_root assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_SUM_AND_ROOT_ASSERT_SVH
`define RADIX_DIGIT_SUM_AND_ROOT_ASSERT_SVH

// same-cycle implication
`define RDSR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdsr check failed");

// next-cycle implication
`define RDSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdsr check failed");

`endif

/* hdl/rdsr_pkg.sv */
// ----------------------------------------------------------------------------
// rdsr_pkg
// Constants and opcodes shared by the digit sum / digital root block.
// ----------------------------------------------------------------------------
`default_nettype none

package rdsr_pkg;

   localparam int RADIX_BITS  = 8;
   localparam int RESULT_BITS = 12;

   localparam logic [RADIX_BITS-1:0]  RADIX_RESET = 8'd10;
   localparam logic [RADIX_BITS-1:0]  RADIX_MIN   = 8'd2;
   localparam logic [RESULT_BITS-1:0] RESULT_MAX  = 12'd2032;

   localparam logic OP_DIGIT_SUM  = 1'b0;
   localparam logic OP_DIGIT_ROOT = 1'b1;

endpackage

`default_nettype wire

/* hdl/rdsr_div.sv */
// ----------------------------------------------------------------------------
// rdsr_div
// Bit-serial restoring divider: one quotient bit per cycle, 8-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rdsr_div #(
   parameter int VALUE_BITS = 63
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [VALUE_BITS-1:0]             dividend,
   input  wire logic [rdsr_pkg::RADIX_BITS-1:0]   divisor,
   output logic                                   done,
   output logic [VALUE_BITS-1:0]                  quotient,
   output logic [rdsr_pkg::RADIX_BITS-1:0]        remainder
);

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
   localparam int RB       = rdsr_pkg::RADIX_BITS;

   logic [VALUE_BITS-1:0] dividend_ff, dividend_in;
   logic [RB-1:0]         remainder_ff, remainder_in;
   logic [RB-1:0]         divisor_ff, divisor_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  done_ff, done_in;

   logic [RB:0] trial;
   logic [RB:0] diff;
   logic        fits;

   always_comb begin
      trial        = {remainder_ff, dividend_ff[VALUE_BITS-1]};
      diff         = trial - {1'b0, divisor_ff};
      fits         = (trial >= {1'b0, divisor_ff});
      dividend_in  = dividend_ff;
      remainder_in = remainder_ff;
      divisor_in   = divisor_ff;
      count_in     = count_ff;
      done_in      = 1'b0;
      if (start) begin
         dividend_in  = dividend;
         remainder_in = '0;
         divisor_in   = divisor;
         count_in     = CNT_BITS'(VALUE_BITS);
      end else if (count_ff != '0) begin
         dividend_in  = {dividend_ff[VALUE_BITS-2:0], fits};
         remainder_in = fits ? diff[RB-1:0] : trial[RB-1:0];
         count_in     = count_ff - 1'b1;
         done_in      = (count_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      dividend_ff  <= dividend_in;
      remainder_ff <= remainder_in;
      divisor_ff   <= divisor_in;
   end

   assign done      = done_ff;
   assign quotient  = dividend_ff;
   assign remainder = remainder_ff;

endmodule

`default_nettype wire

/* hdl/radix_digit_sum_and_root.sv */
// ----------------------------------------------------------------------------
// radix_digit_sum_and_root
// Digit sum (opcode 0) or digital root (opcode 1) of an unsigned operand in a
// programmable radix.
// ----------------------------------------------------------------------------
// One request is worked at a time. A digit sum needs one pass of the
// bit-serial divider per radix digit of the operand (worst case radix 2,
// 63 digits). A digital root takes one pass, and a zero operand takes none.
// The result is presented in the same cycle that the next request can first
// be taken.
// Radix values 0 and 1 act as radix 2. The next request is taken as soon as
// the result moves into the output register, even while it waits there.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_sum_and_root #(
   parameter int VALUE_BITS = 63
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_opcode,
   input  wire logic [VALUE_BITS-1:0]              req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [rdsr_pkg::RESULT_BITS-1:0]        rsp_result,
   input  wire logic                               csr_write_enable,
   input  wire logic [rdsr_pkg::RADIX_BITS-1:0]    csr_write_data
);

   localparam int RB = rdsr_pkg::RADIX_BITS;
   localparam int SB = rdsr_pkg::RESULT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [RB-1:0] radix_ff, radix_in;
   logic          opcode_ff, opcode_in;
   logic [SB-1:0] sum_ff, sum_in;
   logic [RB-1:0] divisor_ff, divisor_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0] rsp_result_ff, rsp_result_in;

   logic                  accept;
   logic                  value_zero;
   logic [RB-1:0]         eff_radix;
   logic [RB-1:0]         first_divisor;
   logic [VALUE_BITS-1:0] first_dividend;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [RB-1:0]         div_divisor;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [RB-1:0]         div_remainder;
   logic                  more_digits;
   logic                  rsp_free;

   always_comb begin
      accept         = req_valid && req_ready;
      value_zero     = (req_value == '0);
      eff_radix      = (radix_ff < rdsr_pkg::RADIX_MIN) ? rdsr_pkg::RADIX_MIN : radix_ff;
      first_divisor  = (req_opcode == rdsr_pkg::OP_DIGIT_ROOT) ? eff_radix - 1'b1 : eff_radix;
      first_dividend = (req_opcode == rdsr_pkg::OP_DIGIT_ROOT) ? req_value - 1'b1 : req_value;
      more_digits    = (div_quotient != '0);
      rsp_free       = !rsp_valid_ff || rsp_ready;
      div_start      = (accept && !value_zero)
                    || (state_ff == ST_DIVIDE && div_done
                        && opcode_ff == rdsr_pkg::OP_DIGIT_SUM && more_digits);
      div_dividend   = (state_ff == ST_IDLE) ? first_dividend : div_quotient;
      div_divisor    = (state_ff == ST_IDLE) ? first_divisor : divisor_ff;
   end

   rdsr_div #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_comb begin
      state_in      = state_ff;
      radix_in      = csr_write_enable ? csr_write_data : radix_ff;
      opcode_in     = opcode_ff;
      sum_in        = sum_ff;
      divisor_in    = divisor_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_result_in = rsp_result_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               opcode_in  = req_opcode;
               sum_in     = '0;
               divisor_in = first_divisor;
               state_in   = value_zero ? ST_FINISH : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (opcode_ff == rdsr_pkg::OP_DIGIT_ROOT) begin
                  sum_in   = SB'(div_remainder) + SB'(1);
                  state_in = ST_FINISH;
               end else begin
                  sum_in = sum_ff + SB'(div_remainder);
                  if (!more_digits) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = sum_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= rdsr_pkg::RADIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      opcode_ff     <= opcode_in;
      sum_ff        <= sum_in;
      divisor_ff    <= divisor_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

`default_nettype wire

/* hdl/rdsr_check.sv */
// ----------------------------------------------------------------------------
// rdsr_check
// Port-level checker for radix_digit_sum_and_root, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix_digit_sum_and_root_assert.svh"

module rdsr_check (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [rdsr_pkg::RESULT_BITS-1:0]   rsp_result
);

   // stalled response keeps its payload
   `RDSR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result))

   // one request in flight: an accepted request closes the input
   `RDSR_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // no digit sum of the operand range exceeds the bound
   `RDSR_ASSERT_NOW(a_result_range, clock, reset, rsp_valid, rsp_result <= rdsr_pkg::RESULT_MAX)

endmodule

bind radix_digit_sum_and_root rdsr_check u_rdsr_check (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_result (rsp_result)
);

`default_nettype wire
